// File: rtl/led_breathing_pwm_engine_core_defines.svh
// Assertion macros for the LED breathing PWM engine.
// No dependencies; included by the checker only.
`ifndef LED_BREATHING_PWM_ENGINE_CORE_DEFINES_SVH
`define LED_BREATHING_PWM_ENGINE_CORE_DEFINES_SVH

// Generic clocked assertion, disabled while in reset.
`define LBPE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Result payload holds while a beat is stalled.
`define LBPE_ASSERT_HOLD(label, sig, msg) \
    `LBPE_ASSERT(label, m_valid && !m_ready |=> $stable(sig), msg)

`endif

// File: rtl/lbpe_pkg.sv
// Shared types and constants for the LED breathing PWM engine.
// No dependencies.
package lbpe_pkg;

    typedef enum logic [1:0] {
        PH_UP   = 2'd0,
        PH_DOWN = 2'd1,
        PH_HOLD = 2'd2,
        PH_DARK = 2'd3
    } phase_t;

    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_PCT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MID_PCT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_PCT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_MID  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_HIGH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DARK      = 3'd6;

    localparam logic [6:0]  RST_LOW_PCT   = 7'd25;
    localparam logic [6:0]  RST_MID_PCT   = 7'd50;
    localparam logic [6:0]  RST_HIGH_PCT  = 7'd100;
    localparam logic [7:0]  RST_HOLD      = 8'd50;
    localparam logic [7:0]  RST_DARK      = 8'd200;

    localparam logic [6:0]  MAX_PERCENT    = 7'd100;
    localparam logic [7:0]  MAX_LIMIT      = 8'd254;
    localparam logic [23:0] NS_PER_PERCENT = 24'd100000;

    typedef struct packed {
        logic [6:0] low_pct;
        logic [6:0] mid_pct;
        logic [6:0] high_pct;
        logic [7:0] hold_low;
        logic [7:0] hold_mid;
        logic [7:0] hold_high;
        logic [7:0] dark;
    } cfg_t;

    typedef struct packed {
        logic       op;
        logic       run_enable;
        logic [7:0] brightness_level;
    } item_t;

    typedef struct packed {
        logic        pwm_write;
        logic [6:0]  duty_percent;
        logic [23:0] pulse_width_ns;
        phase_t      phase;
        logic        running;
    } res_t;

endpackage

// File: rtl/lbpe_cfg_regs.sv
// Configuration register file for the LED breathing PWM engine.
// Depends on lbpe_pkg.
module lbpe_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              wr_en,
    input  logic [lbpe_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [7:0]                        wr_data,
    output lbpe_pkg::cfg_t                    cfg
);

    lbpe_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.low_pct   <= lbpe_pkg::RST_LOW_PCT;
            cfg_reg.mid_pct   <= lbpe_pkg::RST_MID_PCT;
            cfg_reg.high_pct  <= lbpe_pkg::RST_HIGH_PCT;
            cfg_reg.hold_low  <= lbpe_pkg::RST_HOLD;
            cfg_reg.hold_mid  <= lbpe_pkg::RST_HOLD;
            cfg_reg.hold_high <= lbpe_pkg::RST_HOLD;
            cfg_reg.dark      <= lbpe_pkg::RST_DARK;
        end else if (wr_en) begin
            unique case (wr_index)
                lbpe_pkg::REG_LOW_PCT:   cfg_reg.low_pct   <= wr_data[6:0];
                lbpe_pkg::REG_MID_PCT:   cfg_reg.mid_pct   <= wr_data[6:0];
                lbpe_pkg::REG_HIGH_PCT:  cfg_reg.high_pct  <= wr_data[6:0];
                lbpe_pkg::REG_HOLD_LOW:  cfg_reg.hold_low  <= wr_data;
                lbpe_pkg::REG_HOLD_MID:  cfg_reg.hold_mid  <= wr_data;
                lbpe_pkg::REG_HOLD_HIGH: cfg_reg.hold_high <= wr_data;
                lbpe_pkg::REG_DARK:      cfg_reg.dark      <= wr_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/lbpe_step.sv
// Breath sequencer: phase/counter state and the per-beat next-state logic.
// Depends on lbpe_pkg.
module lbpe_step (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            advance,
    input  lbpe_pkg::item_t item,
    input  lbpe_pkg::cfg_t  cfg,
    output lbpe_pkg::res_t  res
);

    lbpe_pkg::phase_t phase_reg, phase_next;
    logic             enabled_reg, enabled_next;
    logic [6:0]       up_count_reg, up_count_next;
    logic [6:0]       down_count_reg, down_count_next;
    logic [7:0]       hold_count_reg, hold_count_next;
    logic [7:0]       dark_count_reg, dark_count_next;

    logic [6:0]  peak_raw, peak;
    logic [7:0]  hold_raw, hold_lim, dark_lim;
    logic        wr;
    logic [6:0]  duty;

    always_comb begin
        // level code match: low wins over mid, anything else is high
        if (item.brightness_level == {1'b0, cfg.low_pct}) begin
            peak_raw = cfg.low_pct;
            hold_raw = cfg.hold_low;
        end else if (item.brightness_level == {1'b0, cfg.mid_pct}) begin
            peak_raw = cfg.mid_pct;
            hold_raw = cfg.hold_mid;
        end else begin
            peak_raw = cfg.high_pct;
            hold_raw = cfg.hold_high;
        end
        peak     = (peak_raw > lbpe_pkg::MAX_PERCENT) ? lbpe_pkg::MAX_PERCENT : peak_raw;
        hold_lim = (hold_raw > lbpe_pkg::MAX_LIMIT) ? lbpe_pkg::MAX_LIMIT : hold_raw;
        dark_lim = (cfg.dark > lbpe_pkg::MAX_LIMIT) ? lbpe_pkg::MAX_LIMIT : cfg.dark;
    end

    always_comb begin
        phase_next      = phase_reg;
        enabled_next    = enabled_reg;
        up_count_next   = up_count_reg;
        down_count_next = down_count_reg;
        hold_count_next = hold_count_reg;
        dark_count_next = dark_count_reg;
        wr              = 1'b0;
        duty            = '0;

        if (item.op) begin
            if (item.run_enable && !enabled_reg) begin
                enabled_next = 1'b1;
                phase_next   = lbpe_pkg::PH_UP;
            end else if (!item.run_enable && enabled_reg) begin
                enabled_next    = 1'b0;
                up_count_next   = '0;
                down_count_next = '0;
                hold_count_next = '0;
                dark_count_next = '0;
                phase_next      = lbpe_pkg::PH_DARK;
            end
        end else if (enabled_reg) begin
            unique case (phase_reg)
                lbpe_pkg::PH_UP: begin
                    if (up_count_reg <= peak) begin
                        wr            = 1'b1;
                        duty          = up_count_reg;
                        up_count_next = up_count_reg + 7'd1;
                    end else begin
                        up_count_next   = '0;
                        down_count_next = peak;
                        phase_next      = lbpe_pkg::PH_HOLD;
                    end
                end
                lbpe_pkg::PH_HOLD: begin
                    if (hold_count_reg <= hold_lim) begin
                        hold_count_next = hold_count_reg + 8'd1;
                    end else begin
                        hold_count_next = '0;
                        phase_next      = lbpe_pkg::PH_DOWN;
                    end
                end
                lbpe_pkg::PH_DOWN: begin
                    if (down_count_reg != '0) begin
                        wr              = 1'b1;
                        duty            = down_count_reg;
                        down_count_next = down_count_reg - 7'd1;
                    end else begin
                        down_count_next = peak;
                        phase_next      = lbpe_pkg::PH_DARK;
                    end
                end
                lbpe_pkg::PH_DARK: begin
                    if (dark_count_reg <= dark_lim) begin
                        dark_count_next = dark_count_reg + 8'd1;
                    end else begin
                        dark_count_next = '0;
                        phase_next      = lbpe_pkg::PH_UP;
                    end
                end
                default: ;
            endcase
        end

        res.pwm_write      = wr;
        res.duty_percent   = duty;
        res.pulse_width_ns = {17'd0, duty} * lbpe_pkg::NS_PER_PERCENT;
        res.phase          = phase_next;
        res.running        = enabled_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= lbpe_pkg::PH_UP;
            enabled_reg    <= 1'b0;
            up_count_reg   <= '0;
            down_count_reg <= '0;
            hold_count_reg <= '0;
            dark_count_reg <= '0;
        end else if (advance) begin
            phase_reg      <= phase_next;
            enabled_reg    <= enabled_next;
            up_count_reg   <= up_count_next;
            down_count_reg <= down_count_next;
            hold_count_reg <= hold_count_next;
            dark_count_reg <= dark_count_next;
        end
    end

endmodule

// File: rtl/led_breathing_pwm_engine_core.sv
// Top level of the LED breathing PWM engine: input register, sequencer, result register.
// Depends on lbpe_pkg, lbpe_cfg_regs, lbpe_step.
//
//   channel | dir | handshake          | payload
//   s_      | in  | s_valid / s_ready  | op, run_enable, brightness_level
//   m_      | out | m_valid / m_ready  | pwm_write, duty_percent, pulse_width_ns, phase, running
//   cfg_    | in  | cfg_valid / ready  | cfg_index (3b), cfg_data (8b)
//
// One beat per cycle sustained while m_ready stays high; each beat passes the input register, then the result register.
// Each beat moves from the input register into the result register when the latter
// is empty or being drained; the sequencer state updates on that same edge.
// While one result is stalled at m_, the input register takes one more beat, then s_ready drops.
// Reset clears state, valids and config to defaults; config is always ready.
module led_breathing_pwm_engine_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_op,
    input  logic                           s_run_enable,
    input  logic [7:0]                     s_brightness_level,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_pwm_write,
    output logic [6:0]                     m_duty_percent,
    output logic [23:0]                    m_pulse_width_ns,
    output logic [1:0]                     m_phase,
    output logic                           m_running,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lbpe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data
);

    lbpe_pkg::cfg_t  cfg;
    lbpe_pkg::item_t item_reg;
    lbpe_pkg::res_t  res, res_reg;
    logic            in_valid_reg, out_valid_reg;
    logic            advance;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;

    lbpe_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    lbpe_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.op               <= s_op;
            item_reg.run_enable       <= s_run_enable;
            item_reg.brightness_level <= s_brightness_level;
        end
        if (advance) begin
            res_reg <= res;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_pwm_write      = res_reg.pwm_write;
    assign m_duty_percent   = res_reg.duty_percent;
    assign m_pulse_width_ns = res_reg.pulse_width_ns;
    assign m_phase          = res_reg.phase;
    assign m_running        = res_reg.running;

endmodule

// File: rtl/lbpe_checker.sv
// Port-level checks for the LED breathing PWM engine, bound to the top level.
// Depends on led_breathing_pwm_engine_core_defines.svh and lbpe_pkg.
`include "led_breathing_pwm_engine_core_defines.svh"

module lbpe_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic                           m_pwm_write,
    input logic [6:0]                     m_duty_percent,
    input logic [23:0]                    m_pulse_width_ns,
    input logic [1:0]                     m_phase,
    input logic                           m_running
);

    `LBPE_ASSERT(a_idle_zero,
        m_valid && !m_pwm_write |-> m_duty_percent == 7'd0 && m_pulse_width_ns == 24'd0,
        "duty or width nonzero without a write")
    `LBPE_ASSERT(a_width,
        m_valid && m_pwm_write |->
            m_pulse_width_ns == 24'(m_duty_percent) * lbpe_pkg::NS_PER_PERCENT,
        "pulse width mismatch")
    `LBPE_ASSERT(a_stopped_phase,
        m_valid && !m_running |->
            !m_pwm_write && (m_phase == lbpe_pkg::PH_UP || m_phase == lbpe_pkg::PH_DARK),
        "stopped engine writing or mid-breath")
    `LBPE_ASSERT_HOLD(a_hold_duty, m_duty_percent, "duty changed while stalled")
    // a draining result always frees the input side
    `LBPE_ASSERT(a_ready_on_drain, m_ready |-> s_ready, "input stalled while output drains")

endmodule

bind led_breathing_pwm_engine_core lbpe_checker u_lbpe_checker (.*);
